FILE: hw/rtl/prefix_code_five_bit_repacker_macros.svh
// ----------------------------------------------------------------------------
// Prefix-code five-bit repacker: assertion macros
// Shared concurrent assertion forms, clocked on aclk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef PREFIX_CODE_FIVE_BIT_REPACKER_MACROS_SVH
`define PREFIX_CODE_FIVE_BIT_REPACKER_MACROS_SVH

// Implication checked at every clock edge while out of reset.
`define PCFBR_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Implication whose consequent is checked at the following clock edge.
`define PCFBR_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: hw/rtl/pcfbr_pkg.sv
// ----------------------------------------------------------------------------
// Prefix-code five-bit repacker: package
// Code table, character classification and symbol-to-character mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package pcfbr_pkg;

    localparam int CHAR_W   = 8;
    localparam int SYM_W    = 5;
    localparam int LEN_W    = 4;
    localparam int CODE_W   = 8;
    localparam int IDX_W    = 5;
    localparam int PEND_W   = 4;
    localparam int PCNT_W   = 3;
    localparam int ACC_W    = PEND_W + CODE_W;
    localparam int TOTAL_W  = 4;

    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
    localparam logic              KIND_CHAR    = 1'b0;
    localparam logic              KIND_FLUSH   = 1'b1;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } lookup_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] bits;
    } code_t;

    // Maps a byte to its code table index; hit is low for ignored bytes.
    function automatic lookup_t char_lookup(input logic [CHAR_W-1:0] c);
        lookup_t r;
        r.hit = 1'b1;
        r.idx = '0;
        if (c >= "A" && c <= "Z") begin
            r.idx = IDX_W'(c - "A" + 8'd6);
        end else begin
            unique case (c)
                " ":     r.idx = 5'd0;
                "'":     r.idx = 5'd1;
                ",":     r.idx = 5'd2;
                "-":     r.idx = 5'd3;
                ".":     r.idx = 5'd4;
                "?":     r.idx = 5'd5;
                default: r.hit = 1'b0;
            endcase
        end
        return r;
    endfunction

    function automatic code_t code_lookup(input logic [IDX_W-1:0] idx);
        code_t r;
        unique case (idx)
            5'd0:  r = '{4'd3, 8'h05};
            5'd1:  r = '{4'd6, 8'h00};
            5'd2:  r = '{4'd6, 8'h03};
            5'd3:  r = '{4'd8, 8'h91};
            5'd4:  r = '{4'd6, 8'h11};
            5'd5:  r = '{4'd6, 8'h01};
            5'd6:  r = '{4'd6, 8'h25};
            5'd7:  r = '{4'd8, 8'h9A};
            5'd8:  r = '{4'd4, 8'h05};
            5'd9:  r = '{4'd4, 8'h01};
            5'd10: r = '{4'd3, 8'h06};
            5'd11: r = '{4'd5, 8'h09};
            5'd12: r = '{4'd8, 8'h9B};
            5'd13: r = '{4'd6, 8'h10};
            5'd14: r = '{4'd4, 8'h07};
            5'd15: r = '{4'd8, 8'h98};
            5'd16: r = '{4'd4, 8'h06};
            5'd17: r = '{4'd5, 8'h04};
            5'd18: r = '{4'd8, 8'h99};
            5'd19: r = '{4'd8, 8'h9E};
            5'd20: r = '{4'd5, 8'h05};
            5'd21: r = '{4'd3, 8'h07};
            5'd22: r = '{4'd8, 8'h9F};
            5'd23: r = '{4'd4, 8'h08};
            5'd24: r = '{4'd5, 8'h06};
            5'd25: r = '{4'd5, 8'h07};
            5'd26: r = '{4'd8, 8'h9C};
            5'd27: r = '{4'd8, 8'h9D};
            5'd28: r = '{4'd6, 8'h02};
            5'd29: r = '{4'd8, 8'h92};
            5'd30: r = '{4'd8, 8'h93};
            default: r = '{4'd8, 8'h90};
        endcase
        return r;
    endfunction

    // Five-bit symbol to output character.
    function automatic logic [CHAR_W-1:0] sym_to_char(input logic [SYM_W-1:0] sym);
        logic [CHAR_W-1:0] r;
        if (sym <= 5'd25) begin
            r = "A" + {3'b000, sym};
        end else begin
            unique case (sym)
                5'd26:   r = " ";
                5'd27:   r = ".";
                5'd28:   r = ",";
                5'd29:   r = "-";
                5'd30:   r = "'";
                default: r = "?";
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/prefix_code_five_bit_repacker.sv
// ----------------------------------------------------------------------------
// Prefix-code five-bit repacker
// Encodes text bytes with a fixed prefix code and repacks the bit stream into
// five-bit symbols printed as characters.
// ----------------------------------------------------------------------------
// An input transaction is registered first, then encoded combinationally into
// up to two result characters, which are held in a two-entry result register
// and handed out one per cycle on the m_ side while m_ready is high. Each
// input passes through the input register and then the result register. A
// transaction that gives two results (two full symbols, or a padded symbol
// followed by a newline) holds the single result port until both are taken
// and the next transaction waits; transactions that give one result or none
// pass one per cycle while m_ready is high. The next input is taken while
// the previous results are still being delivered; the input register only
// passes its transaction on once the result register will be empty in the
// following cycle. The last result of each input transaction carries m_last.
// Bytes that are not in the code alphabet, and a flush with nothing pending,
// give no result and leave the accumulator untouched or emptied respectively.
// ----------------------------------------------------------------------------
`default_nettype none

module prefix_code_five_bit_repacker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_kind,
    input  wire logic [pcfbr_pkg::CHAR_W-1:0]  s_char_code,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [pcfbr_pkg::CHAR_W-1:0]  m_out_char,
    output logic                               m_last
);
    import pcfbr_pkg::*;

    `include "prefix_code_five_bit_repacker_macros.svh"

    // Input register.
    logic              in_valid_reg;
    logic              in_kind_reg;
    logic [CHAR_W-1:0] in_char_reg;

    // Accumulator of leftover code bits, oldest bit most significant.
    logic [PEND_W-1:0] pend_bits_reg, pend_bits_next;
    logic [PCNT_W-1:0] pend_cnt_reg, pend_cnt_next;

    // Result register: up to two characters, delivered res0 first.
    logic [CHAR_W-1:0] res0_reg, res1_reg;
    logic [1:0]        res_cnt_reg;

    // Encoder outputs.
    logic [CHAR_W-1:0] enc_c0, enc_c1;
    logic [1:0]        enc_n;

    logic              out_take;
    logic              drain_done;
    logic              move;

    lookup_t            lk;
    code_t              cd;
    logic [ACC_W-1:0]   acc;
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] rem;
    logic [SYM_W-1:0]   sym_hi, sym_lo, sym_pad;
    logic [ACC_W-1:0]   rem_mask;

    assign out_take   = m_valid && m_ready;
    // The result register will be empty at the next edge.
    assign drain_done = (res_cnt_reg == 2'd0) || (res_cnt_reg == 2'd1 && m_ready);
    assign move       = in_valid_reg && drain_done;
    assign s_ready    = !in_valid_reg || move;

    // Encoder: append the code to the pending bits and cut off whole symbols.
    always_comb begin
        lk      = char_lookup(in_char_reg);
        cd      = code_lookup(lk.idx);
        acc     = (ACC_W'(pend_bits_reg) << cd.len) | ACC_W'(cd.bits);
        total   = TOTAL_W'(pend_cnt_reg) + cd.len;
        sym_hi  = SYM_W'(acc >> (total - TOTAL_W'(5)));
        sym_lo  = SYM_W'(acc >> (total - TOTAL_W'(10)));
        rem     = (total >= TOTAL_W'(10)) ? total - TOTAL_W'(10)
                : (total >= TOTAL_W'(5))  ? total - TOTAL_W'(5) : total;
        rem_mask = ~(ACC_W'({ACC_W{1'b1}}) << rem);
        // Pending bits left-aligned into a symbol and padded with zeros.
        sym_pad = SYM_W'({1'b0, pend_bits_reg} << (PCNT_W'(5) - pend_cnt_reg));

        enc_c0         = NEWLINE_CHAR;
        enc_c1         = NEWLINE_CHAR;
        enc_n          = 2'd0;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;

        if (in_kind_reg == KIND_FLUSH) begin
            pend_bits_next = '0;
            pend_cnt_next  = '0;
            if (pend_cnt_reg != '0) begin
                enc_c0 = sym_to_char(sym_pad);
                enc_n  = 2'd1;
            end
        end else if (in_char_reg == NEWLINE_CHAR) begin
            pend_bits_next = '0;
            pend_cnt_next  = '0;
            if (pend_cnt_reg != '0) begin
                enc_c0 = sym_to_char(sym_pad);
                enc_n  = 2'd2;
            end else begin
                enc_n  = 2'd1;
            end
        end else if (lk.hit) begin
            pend_bits_next = PEND_W'(acc & rem_mask);
            pend_cnt_next  = PCNT_W'(rem);
            if (total >= TOTAL_W'(10)) begin
                enc_c0 = sym_to_char(sym_hi);
                enc_c1 = sym_to_char(sym_lo);
                enc_n  = 2'd2;
            end else if (total >= TOTAL_W'(5)) begin
                enc_c0 = sym_to_char(sym_hi);
                enc_n  = 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            res_cnt_reg   <= 2'd0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (move) begin
                in_valid_reg <= 1'b0;
            end

            if (move) begin
                pend_bits_reg <= pend_bits_next;
                pend_cnt_reg  <= pend_cnt_next;
                res_cnt_reg   <= enc_n;
            end else if (out_take) begin
                res_cnt_reg   <= res_cnt_reg - 2'd1;
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg <= s_kind;
            in_char_reg <= s_char_code;
        end
        if (move) begin
            res0_reg <= enc_c0;
            res1_reg <= enc_c1;
        end else if (out_take) begin
            res0_reg <= res1_reg;
        end
    end

    assign m_valid    = (res_cnt_reg != 2'd0);
    assign m_out_char = res0_reg;
    assign m_last     = (res_cnt_reg == 2'd1);

    `PCFBR_ASSERT_IMPL(a_pend_cnt_range, 1'b1, pend_cnt_reg <= PCNT_W'(4), "pending count above four")
    `PCFBR_ASSERT_IMPL(a_res_cnt_range, 1'b1, res_cnt_reg <= 2'd2, "result count above two")
    `PCFBR_ASSERT_NEXT(a_two_results_first, move && enc_n == 2'd2, m_valid && !m_last, "first of two results not shown")
    `PCFBR_ASSERT_NEXT(a_second_result_last, out_take && res_cnt_reg == 2'd2, m_valid && m_last, "second result lost")
    `PCFBR_ASSERT_NEXT(a_flush_empties, move && in_kind_reg == KIND_FLUSH, pend_cnt_reg == '0, "flush left bits pending")

endmodule

`default_nettype wire
